// ===== hdl/gregorian_date_arithmetic_defines.svh =====
// ----------------------------------------------------------------------------
// Gregorian date arithmetic: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GDA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GDA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/gda_pkg.sv =====
// ----------------------------------------------------------------------------
// Gregorian date arithmetic package
// Widths, calendar tables and the year unit's result type.
// ----------------------------------------------------------------------------
package gda_pkg;

   // Internal year width covers every legal MAX_YEAR.
   localparam int YEAR_W = 16;
   // Day serial width: days before year 65536 plus one year fit in 25 bits.
   localparam int SER_W  = 25;
   // Days left inside one year.
   localparam int REM_W  = 9;
   // Quotient of a 16-bit year by 100.
   localparam int QUO_W  = 10;

   localparam int DEFAULT_YEAR = 1999;
   localparam int MONTHS       = 12;
   localparam int FEB_DAYS     = 28;
   localparam int CENTURY      = 100;
   localparam int QUAD_CENTURY = 400;

   // ceil(2^23 / 100): exact year / 100 for every 16-bit year.
   localparam int          RECIP_SHIFT = 23;
   localparam logic [16:0] RECIP_100   = 17'd83887;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] MONTH_LEN_TBL [16] = '{
      5'd0, 5'd31, 5'(FEB_DAYS), 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0};

   localparam logic [8:0] CUM_DAYS_TBL [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0};

   // Result of the shared year unit.
   typedef struct packed {
      logic             done;
      logic             leap;
      logic [SER_W-1:0] dby;
   } gda_year_type;

   // Length of a month; zero for a month code outside 1..12.
   function automatic logic [4:0] gda_month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      len = MONTH_LEN_TBL[m];
      if (m == MONTH_FEB && leap) begin
         len = 5'(FEB_DAYS + 1);
      end
      return len;
   endfunction

   // Days in the months before month m of a year.
   function automatic logic [8:0] gda_cum_days(input logic [3:0] m, input logic leap);
      logic [8:0] cum;
      cum = CUM_DAYS_TBL[m];
      if (leap && m > MONTH_FEB) begin
         cum = cum + 9'd1;
      end
      return cum;
   endfunction

   // Elaboration-time count of days in all years before year y.
   function automatic int gda_dby_const(input int y);
      int p;
      p = y - 1;
      return 365 * p + p / 4 - p / CENTURY + p / QUAD_CENTURY;
   endfunction

   // Day serial of the replacement date DEFAULT_YEAR-01-01.
   localparam logic [SER_W-1:0] DEFAULT_SERIAL = SER_W'(gda_dby_const(DEFAULT_YEAR) + 1);

endpackage

// ===== hdl/gda_year_unit.sv =====
// ----------------------------------------------------------------------------
// Gregorian date arithmetic: year unit
// Three-stage pipeline that gives the leap flag of a year and the number of
// days in all years before it.
// ----------------------------------------------------------------------------
module gda_year_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [15:0]          year,
   output gda_pkg::gda_year_type info
);
   import gda_pkg::*;

   logic                 v1_ff, v2_ff, done_ff;
   logic [YEAR_W-1:0]    y1_ff;
   logic [32:0]          prod_ff;
   logic [QUO_W-1:0]     q;
   logic                 r_zero;
   logic [QUO_W-1:0]     pq_in, pq_ff;
   logic [YEAR_W-1:0]    p_in, p_ff;
   logic [SER_W-1:0]     p365_ff;
   logic                 leap_in, leap_ff, leap_out_ff;
   logic [SER_W-1:0]     dby_in, dby_ff;

   // Stage two: quotient by 100, exact-century test and leap rule.
   always_comb begin
      q       = prod_ff[RECIP_SHIFT +: QUO_W];
      r_zero  = (y1_ff == YEAR_W'(YEAR_W'(q) * YEAR_W'(CENTURY)));
      pq_in   = r_zero ? q - QUO_W'(1) : q;
      p_in    = y1_ff - YEAR_W'(1);
      leap_in = (y1_ff[1:0] == 2'b00) && (!r_zero || q[1:0] == 2'b00);
   end

   // Stage three: 365 p + p/4 - p/100 + p/400.
   always_comb begin
      dby_in = p365_ff + SER_W'(p_ff >> 2) - SER_W'(pq_ff) + SER_W'(pq_ff >> 2);
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= go;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff;
      end
   end

   // Pipeline data.
   always_ff @(posedge clock) begin
      y1_ff       <= year;
      prod_ff     <= 33'(year) * 33'(RECIP_100);
      pq_ff       <= pq_in;
      p_ff        <= p_in;
      p365_ff     <= SER_W'(p_in) * SER_W'(365);
      leap_ff     <= leap_in;
      leap_out_ff <= leap_ff;
      dby_ff      <= dby_in;
   end

   assign info.done = done_ff;
   assign info.leap = leap_out_ff;
   assign info.dby  = dby_ff;

endmodule

// ===== hdl/gregorian_date_arithmetic.sv =====
// ----------------------------------------------------------------------------
// Gregorian date arithmetic
// Adds a signed day offset to a date, or measures the distance between dates.
// ----------------------------------------------------------------------------
// One item at a time: busy is high from the accepting edge until the result
// strobe, and rsp_valid is high for exactly one cycle with no way to hold it.
// The shared year unit turns a year into a day count. A difference item runs
// both dates through the year unit in turn and then compares the two serials.
// An add item runs the first date through the year unit, clamps the sum, makes
// at most ceil(log2(MAX_YEAR)) year probes, fetches the final year and then
// steps through the months up to the result month.
// The result year is found by a binary search over the years.
// Invalid dates are replaced by 1999-01-01 before use.
// ----------------------------------------------------------------------------
`include "gregorian_date_arithmetic_defines.svh"

module gregorian_date_arithmetic #(
   parameter int MAX_YEAR = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_func,
   input  logic [13:0]        req_first_year,
   input  logic [3:0]         req_first_month,
   input  logic [4:0]         req_first_day,
   input  logic signed [20:0] req_day_offset,
   input  logic [13:0]        req_second_year,
   input  logic [3:0]         req_second_month,
   input  logic [4:0]         req_second_day,
   output logic               rsp_valid,
   output logic [13:0]        rsp_result_year,
   output logic [3:0]         rsp_result_month,
   output logic [4:0]         rsp_result_day,
   output logic [21:0]        rsp_day_count,
   output logic               rsp_first_greater,
   output logic               rsp_dates_equal,
   output logic               rsp_out_of_range
);
   import gda_pkg::*;

   localparam logic [YEAR_W-1:0] MAX_YEAR_W = YEAR_W'(MAX_YEAR);
   localparam logic [SER_W-1:0]  TOP_SERIAL = SER_W'(gda_dby_const(MAX_YEAR + 1));
   localparam logic [21:0]       COUNT_MAX  = '1;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_VAL1   = 4'd1;
   localparam logic [3:0] ST_VAL2   = 4'd2;
   localparam logic [3:0] ST_CLAMP  = 4'd3;
   localparam logic [3:0] ST_DIFF   = 4'd4;
   localparam logic [3:0] ST_SEARCH = 4'd5;
   localparam logic [3:0] ST_PROBE  = 4'd6;
   localparam logic [3:0] ST_LAST   = 4'd7;
   localparam logic [3:0] ST_MONTH  = 4'd8;

   logic [3:0]          st_in, st_ff;
   logic                func_in, func_ff;
   logic [13:0]         y1_in, y1_ff, y2_in, y2_ff;
   logic [3:0]          m1_in, m1_ff, m2_in, m2_ff;
   logic [4:0]          d1_in, d1_ff, d2_in, d2_ff;
   logic signed [20:0]  off_in, off_ff;
   logic [SER_W-1:0]    s1_in, s1_ff, s2_in, s2_ff, n_in, n_ff;
   logic [YEAR_W-1:0]   lo_in, lo_ff, hi_in, hi_ff, mid;
   logic                leap_in, leap_ff, oor_in, oor_ff;
   logic [REM_W-1:0]    rem_in, rem_ff;
   logic [3:0]          mo_in, mo_ff;
   logic                rsp_valid_in, rsp_valid_ff;
   logic [13:0]         ry_in, ry_ff;
   logic [3:0]          rm_in, rm_ff;
   logic [4:0]          rd_in, rd_ff;
   logic [21:0]         cnt_in, cnt_ff;
   logic                gt_in, gt_ff, eq_in, eq_ff, roor_in, roor_ff;
   logic                unit_go;
   logic [YEAR_W-1:0]   unit_year;
   gda_year_type        yr;
   logic signed [25:0]  sum_s;
   logic [SER_W-1:0]    diff;
   logic [4:0]          len;
   logic                rsp_is_add, rsp_add_ok, rsp_flags_ok;

   // Day serial of a date once its year is known, or of 1999-01-01 if invalid.
   function automatic logic [SER_W-1:0] date_serial(input logic [13:0] y,
                                                    input logic [3:0] m,
                                                    input logic [4:0] d,
                                                    input gda_year_type info);
      logic ok;
      ok = (y != 14'd0) && (YEAR_W'(y) <= MAX_YEAR_W) &&
           (m >= MONTH_JAN) && (m <= MONTH_DEC) &&
           (d != 5'd0) && (d <= gda_month_len(m, info.leap));
      return ok ? info.dby + SER_W'(gda_cum_days(m, info.leap)) + SER_W'(d)
                : DEFAULT_SERIAL;
   endfunction

   // Shared year-to-day-count unit.
   gda_year_unit u_year (
      .clock (clock),
      .reset (reset),
      .go    (unit_go),
      .year  (unit_year),
      .info  (yr)
   );

   // Sequencer and datapath next values.
   always_comb begin
      st_in        = st_ff;
      func_in      = func_ff;
      y1_in        = y1_ff;
      m1_in        = m1_ff;
      d1_in        = d1_ff;
      off_in       = off_ff;
      y2_in        = y2_ff;
      m2_in        = m2_ff;
      d2_in        = d2_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      leap_in      = leap_ff;
      oor_in       = oor_ff;
      rem_in       = rem_ff;
      mo_in        = mo_ff;
      rsp_valid_in = 1'b0;
      ry_in        = ry_ff;
      rm_in        = rm_ff;
      rd_in        = rd_ff;
      cnt_in       = cnt_ff;
      gt_in        = gt_ff;
      eq_in        = eq_ff;
      roor_in      = roor_ff;
      unit_go      = 1'b0;
      unit_year    = lo_ff;
      mid          = YEAR_W'(((YEAR_W+1)'(lo_ff) + (YEAR_W+1)'(hi_ff) + (YEAR_W+1)'(1)) >> 1);
      sum_s        = signed'({1'b0, s1_ff}) + 26'(off_ff);
      diff         = (s1_ff > s2_ff) ? s1_ff - s2_ff : s2_ff - s1_ff;
      len          = gda_month_len(mo_ff, leap_ff);

      unique case (st_ff)
         ST_IDLE: begin
            if (start) begin
               func_in   = req_func;
               y1_in     = req_first_year;
               m1_in     = req_first_month;
               d1_in     = req_first_day;
               off_in    = req_day_offset;
               y2_in     = req_second_year;
               m2_in     = req_second_month;
               d2_in     = req_second_day;
               oor_in    = 1'b0;
               unit_go   = 1'b1;
               unit_year = YEAR_W'(req_first_year);
               st_in     = ST_VAL1;
            end
         end
         ST_VAL1: begin
            if (yr.done) begin
               s1_in = date_serial(y1_ff, m1_ff, d1_ff, yr);
               if (func_ff) begin
                  unit_go   = 1'b1;
                  unit_year = YEAR_W'(y2_ff);
                  st_in     = ST_VAL2;
               end else begin
                  st_in = ST_CLAMP;
               end
            end
         end
         ST_VAL2: begin
            if (yr.done) begin
               s2_in = date_serial(y2_ff, m2_ff, d2_ff, yr);
               st_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            // Distance with saturation, plus the order flags.
            ry_in        = '0;
            rm_in        = '0;
            rd_in        = '0;
            gt_in        = s1_ff > s2_ff;
            eq_in        = s1_ff == s2_ff;
            roor_in      = diff > SER_W'(COUNT_MAX);
            cnt_in       = roor_in ? COUNT_MAX : diff[21:0];
            rsp_valid_in = 1'b1;
            st_in        = ST_IDLE;
         end
         ST_CLAMP: begin
            // Sum serial, held inside the first day through MAX_YEAR-12-31.
            if (sum_s < 26'sd1) begin
               n_in   = SER_W'(1);
               oor_in = 1'b1;
            end else if (sum_s > signed'({1'b0, TOP_SERIAL})) begin
               n_in   = TOP_SERIAL;
               oor_in = 1'b1;
            end else begin
               n_in = sum_s[SER_W-1:0];
            end
            lo_in = YEAR_W'(1);
            hi_in = MAX_YEAR_W;
            st_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            // Probe the midpoint, or fetch the final year once the range closes.
            unit_go = 1'b1;
            if (lo_ff < hi_ff) begin
               unit_year = mid;
               st_in     = ST_PROBE;
            end else begin
               unit_year = lo_ff;
               st_in     = ST_LAST;
            end
         end
         ST_PROBE: begin
            if (yr.done) begin
               if (yr.dby < n_ff) begin
                  lo_in = mid;
               end else begin
                  hi_in = mid - YEAR_W'(1);
               end
               st_in = ST_SEARCH;
            end
         end
         ST_LAST: begin
            if (yr.done) begin
               rem_in  = REM_W'(n_ff - yr.dby);
               leap_in = yr.leap;
               mo_in   = MONTH_JAN;
               st_in   = ST_MONTH;
            end
         end
         ST_MONTH: begin
            // One month per cycle until the remaining days fit.
            if (mo_ff < MONTH_DEC && rem_ff > REM_W'(len)) begin
               rem_in = rem_ff - REM_W'(len);
               mo_in  = mo_ff + 4'd1;
            end else begin
               ry_in        = lo_ff[13:0];
               rm_in        = mo_ff;
               rd_in        = rem_ff[4:0];
               cnt_in       = '0;
               gt_in        = 1'b0;
               eq_in        = 1'b0;
               roor_in      = oor_ff;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and work registers.
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      y1_ff   <= y1_in;
      m1_ff   <= m1_in;
      d1_ff   <= d1_in;
      off_ff  <= off_in;
      y2_ff   <= y2_in;
      m2_ff   <= m2_in;
      d2_ff   <= d2_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      n_ff    <= n_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      leap_ff <= leap_in;
      oor_ff  <= oor_in;
      rem_ff  <= rem_in;
      mo_ff   <= mo_in;
      ry_ff   <= ry_in;
      rm_ff   <= rm_in;
      rd_ff   <= rd_in;
      cnt_ff  <= cnt_in;
      gt_ff   <= gt_in;
      eq_ff   <= eq_in;
      roor_ff <= roor_in;
   end

   assign busy              = (st_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_year   = ry_ff;
   assign rsp_result_month  = rm_ff;
   assign rsp_result_day    = rd_ff;
   assign rsp_day_count     = cnt_ff;
   assign rsp_first_greater = gt_ff;
   assign rsp_dates_equal   = eq_ff;
   assign rsp_out_of_range  = roor_ff;

   // Shape of a result item, as seen by the checks below.
   assign rsp_is_add   = rsp_valid && (rsp_result_month != 4'd0);
   assign rsp_add_ok   = (rsp_result_month <= MONTH_DEC) && (rsp_result_day != 5'd0) &&
                         (rsp_day_count == 22'd0) && !rsp_dates_equal;
   assign rsp_flags_ok = !(rsp_first_greater && rsp_dates_equal);

   // Checks on sequencing and result consistency.
   `GDA_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, !busy, "result strobe while busy")
   `GDA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item not busy")
   `GDA_ASSERT_IMP(a_flags_excl, clock, reset, rsp_valid, rsp_flags_ok, "greater and equal set")
   `GDA_ASSERT_IMP(a_add_date, clock, reset, rsp_is_add, rsp_add_ok, "malformed sum date")

endmodule
